/* sv/cgp_pkg.sv */
// Package: formats, pipeline stage map, register indexes and power tables.
package cgp_pkg;

  localparam int CHANNEL_COUNT = 4;
  localparam int SAMPLE_BITS   = 16;
  localparam int COEF_BITS     = 16;
  localparam int FRAC_F        = SAMPLE_BITS - 4;
  localparam int FRAC_W        = FRAC_F + 8;
  localparam int POW_SH        = FRAC_W - 16;

  localparam int CFG_ADDR_BITS = 8;
  localparam int CFG_DATA_BITS = CHANNEL_COUNT * COEF_BITS;

  localparam logic [CFG_ADDR_BITS-1:0] REG_SLOPE     = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] REG_INTERCEPT = CFG_ADDR_BITS'(1);
  localparam logic [CFG_ADDR_BITS-1:0] REG_EXPONENT  = CFG_ADDR_BITS'(2);
  localparam logic [CFG_ADDR_BITS-1:0] REG_ENABLE    = CFG_ADDR_BITS'(3);
  localparam logic [CFG_ADDR_BITS-1:0] REG_REVERSE   = CFG_ADDR_BITS'(4);
  localparam logic [CFG_ADDR_BITS-1:0] REG_CLAMP_BLK = CFG_ADDR_BITS'(5);
  localparam logic [CFG_ADDR_BITS-1:0] REG_CLAMP_WHT = CFG_ADDR_BITS'(6);

  localparam logic [CFG_DATA_BITS-1:0] SLOPE_RST    = 64'h0100_0100_0100_0100;
  localparam logic [CFG_DATA_BITS-1:0] EXPONENT_RST = 64'h0100_0100_0100_0100;
  localparam logic [CHANNEL_COUNT-1:0] ENABLE_RST   = 4'b0111;
  localparam logic [COEF_BITS-1:0]     EXP_ONE      = 16'h0100;

  // stage map of the grading pipeline
  localparam int S_LIN      = 0;
  localparam int S_NORM     = 1;
  localparam int S_LOG      = 2;
  localparam int S_LG       = 3;
  localparam int S_MUL      = 4;
  localparam int S_EXP      = 5;
  localparam int S_POW      = 6;
  localparam int S_NUM      = 7;
  localparam int S_DIV      = 8;
  localparam int S_QUO      = 9;
  localparam int QUO_BITS   = SAMPLE_BITS - 1;
  localparam int DIV_STEP   = 3;
  localparam int DIV_STAGES = QUO_BITS / DIV_STEP;
  localparam int S_OUT      = S_QUO + DIV_STAGES;
  localparam int NSTG       = S_OUT + 1;

  // power datapath widths
  localparam int MAG_BITS       = 32;
  localparam int FR_BITS        = 30;
  localparam int LOG_DEPTH_BITS = 8;
  localparam int LOG_TABLE_DEPTH = 1 << LOG_DEPTH_BITS;
  localparam int FR_LO_BITS     = FR_BITS - LOG_DEPTH_BITS;
  localparam int F_LO_BITS      = 16 - LOG_DEPTH_BITS;
  localparam int LOG_ENT_BITS   = 17;
  localparam int EXP_ENT_BITS   = 18;
  localparam int LG_BITS        = 23;
  localparam int LP_BITS        = 40;
  localparam int Q_BITS         = 32;
  localparam int N_BITS         = 16;
  localparam int SH_BITS        = 17;
  localparam int SH_CAP         = 15;
  localparam int SH_FLOOR       = 17;
  localparam logic [MAG_BITS-1:0] POW_CAP = 32'h8000_0000;
  localparam logic [30:0]         NM_CLIP = 31'h4000_0000;

  typedef logic [LOG_TABLE_DEPTH:0][LOG_ENT_BITS-1:0] log_tab_t;
  typedef logic [LOG_TABLE_DEPTH:0][EXP_ENT_BITS-1:0] exp_tab_t;

  typedef struct packed {
    logic [COEF_BITS-1:0] slope;
    logic [COEF_BITS-1:0] intercept;
    logic [COEF_BITS-1:0] exponent;
    logic                 enabled;
    logic                 reverse;
    logic                 clamp_black;
    logic                 clamp_white;
  } lane_ctl_t;

  // U0.16 log2 of a U1.30 value in [1,2) by repeated squaring
  function automatic logic [15:0] log2_serial(logic [63:0] y_in);
    logic [63:0] y;
    logic [15:0] r;
    y = y_in;
    r = '0;
    for (int k = 15; k >= 0; k--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        r[k] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t t;
    for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
      t[i] = {1'b0, log2_serial((64'd1 << 30) + ((64'(i) << 30) >> LOG_DEPTH_BITS))};
    end
    t[LOG_TABLE_DEPTH] = LOG_ENT_BITS'(65536);
    return t;
  endfunction

  // least mantissa whose log2 reaches each table point
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t t;
    logic [63:0] lo, hi, mid, target;
    for (int j = 0; j < LOG_TABLE_DEPTH; j++) begin
      target = (64'(j) << 16) >> LOG_DEPTH_BITS;
      lo = 64'd65536;
      hi = 64'd131071;
      for (int it = 0; it < 18; it++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (64'(log2_serial(mid << 14)) >= target) hi = mid;
          else lo = mid + 64'd1;
        end
      end
      t[j] = EXP_ENT_BITS'(lo);
    end
    t[LOG_TABLE_DEPTH] = EXP_ENT_BITS'(131072);
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();
  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

/* sv/cgp_in_if.sv */
// Input pixel channel: valid/ready handshake with four signed samples.
interface cgp_in_if import cgp_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] red_in;
  logic signed [SAMPLE_BITS-1:0] green_in;
  logic signed [SAMPLE_BITS-1:0] blue_in;
  logic signed [SAMPLE_BITS-1:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input alpha_in, output ready);
endinterface

/* sv/cgp_out_if.sv */
// Result pixel channel: valid/ready handshake with four graded samples.
interface cgp_out_if import cgp_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] red_out;
  logic signed [SAMPLE_BITS-1:0] green_out;
  logic signed [SAMPLE_BITS-1:0] blue_out;
  logic signed [SAMPLE_BITS-1:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input alpha_out, output ready);
endinterface

/* sv/cgp_lane.sv */
// Grading datapath of one color channel: linear term, log/exp power, divide, clamp.
module cgp_lane import cgp_pkg::*; (
  input  logic                          clk,
  input  lane_ctl_t                     ctl,
  input  logic [NSTG-1:0]               stage_en,
  input  logic signed [SAMPLE_BITS-1:0] x_in,
  output logic signed [SAMPLE_BITS-1:0] y_out
);

  typedef struct packed {
    logic                  neg;
    logic                  direct;
    logic                  zero;
    logic [MAG_BITS-1:0]   dpm;
  } side_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] rf;
    logic                   qsat;
    logic                   qneg;
    logic                   nneg;
    logic                   nzero;
  } fin_t;

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SONE = SAMPLE_BITS'(1 << FRAC_F);

  logic signed [SAMPLE_BITS-1:0] x_r [S_OUT];

  // stage registers
  logic                      neg0_r;
  logic [MAG_BITS-1:0]       mag0_r;
  logic [FR_BITS-1:0]        fr1_r;
  logic signed [5:0]         lexp1_r, lexp2_r;
  side_t                     sd1_r, sd2_r, sd3_r, sd4_r, sd5_r;
  logic [LOG_ENT_BITS-1:0]   la2_r, ip2_r;
  logic signed [LG_BITS-1:0] lg3_r;
  logic signed [LP_BITS-1:0] lp4_r;
  logic [EXP_ENT_BITS-1:0]   ea5_r, ep5_r;
  logic signed [N_BITS-1:0]  n5_r;
  logic [MAG_BITS-1:0]       pm6_r;
  logic                      neg6_r;
  logic [SAMPLE_BITS-1:0]    rf7_r;
  logic signed [33:0]        num7_r;
  logic [31:0]               dd8_r;
  fin_t                      fin8_r;
  logic [31:0]               rem_r [DIV_STAGES];
  logic [QUO_BITS-1:0]       q_r [DIV_STAGES];
  fin_t                      fin_r [DIV_STAGES];

  // combinational values
  logic signed [31:0]        prod_c;
  logic signed [32:0]        lin_c, base_c;
  logic                      neg_c;
  logic [MAG_BITS-1:0]       mag_c;
  logic [4:0]                p_c;
  logic [MAG_BITS-1:0]       norm_c;
  logic signed [5:0]         lexp_c;
  side_t                     sd_c;
  logic [LOG_DEPTH_BITS-1:0] li_c;
  logic [LOG_DEPTH_BITS:0]   li1_c;
  logic [LOG_ENT_BITS-1:0]   la_c, lb_c, dl_c;
  logic [38:0]               lip_c;
  logic signed [LG_BITS-1:0] lg_c;
  logic signed [LP_BITS-1:0] lp_c;
  logic signed [Q_BITS-1:0]  q_c;
  logic [LOG_DEPTH_BITS-1:0] ej_c;
  logic [LOG_DEPTH_BITS:0]   ej1_c;
  logic [EXP_ENT_BITS-1:0]   ea_c, eb_c, dx_c;
  logic [25:0]               eip_c;
  logic [EXP_ENT_BITS-1:0]   ef_c;
  logic signed [SH_BITS-1:0] sh_c;
  logic [4:0]                rk_c;
  logic [18:0]               rt_c;
  logic [MAG_BITS-1:0]       pm_c;
  logic [24:0]               rnd_c;
  logic [SAMPLE_BITS-1:0]    rf_c;
  logic signed [33:0]        num_c;
  logic [33:0]               nmf_c;
  logic [30:0]               nm_c;
  logic [SAMPLE_BITS-1:0]    sm_c;
  logic [SAMPLE_BITS:0]      dv_c;
  logic [31:0]               dd_c;
  fin_t                      fin_c;
  logic signed [SAMPLE_BITS-1:0] rv_c, r_c, y_c;

  // linear term and base of the power
  always_comb begin
    prod_c = $signed(ctl.slope) * x_in;
    lin_c  = 33'(prod_c) + (33'($signed(ctl.intercept)) <<< FRAC_F);
    base_c = ctl.reverse ? 33'(x_in) : lin_c;
    neg_c  = base_c[32];
    mag_c  = MAG_BITS'(neg_c ? -base_c : base_c);
  end

  // leading one and mantissa
  always_comb begin
    p_c = '0;
    for (int k = 0; k < MAG_BITS; k++) begin
      if (mag0_r[k]) p_c = 5'(k);
    end
    norm_c    = mag0_r << (5'd31 - p_c);
    lexp_c    = $signed({1'b0, p_c}) - (ctl.reverse ? 6'(FRAC_F) : 6'(FRAC_W));
    sd_c.neg    = neg0_r;
    sd_c.direct = (ctl.exponent == EXP_ONE);
    sd_c.zero   = (mag0_r == '0);
    sd_c.dpm    = ctl.reverse ? (mag0_r << 8) : mag0_r;
  end

  // log2 table with interpolation
  always_comb begin
    li_c  = fr1_r[FR_BITS-1 -: LOG_DEPTH_BITS];
    li1_c = {1'b0, li_c} + 1'b1;
    la_c  = LOG_TAB[li_c];
    lb_c  = LOG_TAB[li1_c];
    dl_c  = lb_c - la_c;
    lip_c = 39'(dl_c) * 39'(fr1_r[FR_LO_BITS-1:0]);
  end

  assign lg_c = (LG_BITS'(lexp2_r) <<< 16) + LG_BITS'(la2_r) + LG_BITS'(ip2_r);
  assign lp_c = lg3_r * $signed({1'b0, ctl.exponent});

  // exp2 table with interpolation
  always_comb begin
    q_c   = Q_BITS'((lp4_r + LP_BITS'(128)) >>> 8);
    ej_c  = q_c[15 -: LOG_DEPTH_BITS];
    ej1_c = {1'b0, ej_c} + 1'b1;
    ea_c  = EXP_TAB[ej_c];
    eb_c  = EXP_TAB[ej1_c];
    dx_c  = eb_c - ea_c;
    eip_c = 26'(dx_c) * 26'(q_c[F_LO_BITS-1:0]);
  end

  // scale the power to the wide fraction format, cap large values, flush small ones to zero
  always_comb begin
    ef_c = ea5_r + ep5_r;
    sh_c = SH_BITS'(n5_r) + SH_BITS'(POW_SH);
    rk_c = 5'(-sh_c);
    // keep one extra bit below the cut to round half up
    rt_c = {ef_c, 1'b0} >> rk_c;
    if (sd5_r.direct) pm_c = sd5_r.dpm;
    else if (sd5_r.zero) pm_c = '0;
    else if (sh_c >= SH_BITS'(SH_CAP)) pm_c = POW_CAP;
    else if (sh_c >= 0) pm_c = MAG_BITS'(ef_c) << sh_c[3:0];
    else if (sh_c < -SH_BITS'(SH_FLOOR)) pm_c = '0;
    else pm_c = MAG_BITS'((20'(rt_c) + 20'd1) >> 1);
  end

  // forward result and reverse numerator
  always_comb begin
    rnd_c = 25'((33'(pm6_r) + 33'd128) >> 8);
    if (rnd_c >= 25'(1 << (SAMPLE_BITS-1))) rf_c = neg6_r ? SMIN : SMAX;
    else rf_c = neg6_r ? -SAMPLE_BITS'(rnd_c) : SAMPLE_BITS'(rnd_c);
    num_c = (neg6_r ? -34'(pm6_r) : 34'(pm6_r))
            - (34'($signed(ctl.intercept)) <<< FRAC_F);
  end

  // divider setup: rounded quotient as (2n + s) / 2s
  always_comb begin
    sm_c  = ctl.slope[COEF_BITS-1] ? -ctl.slope : ctl.slope;
    dv_c  = {sm_c, 1'b0};
    nmf_c = 34'(num7_r[33] ? -num7_r : num7_r);
    nm_c  = (nmf_c >= 34'(NM_CLIP)) ? NM_CLIP : nmf_c[30:0];
    dd_c  = {nm_c, 1'b0} + 32'(sm_c);
    fin_c.rf    = rf7_r;
    fin_c.qsat  = dd_c >= (32'(dv_c) << QUO_BITS);
    fin_c.nneg  = num7_r[33];
    fin_c.nzero = (num7_r == '0);
    fin_c.qneg  = num7_r[33] != ctl.slope[COEF_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (stage_en[S_LIN]) begin
      x_r[S_LIN] <= x_in;
      neg0_r     <= neg_c;
      mag0_r     <= mag_c;
    end
    if (stage_en[S_NORM]) begin
      fr1_r   <= norm_c[FR_BITS:1];
      lexp1_r <= lexp_c;
      sd1_r   <= sd_c;
    end
    if (stage_en[S_LOG]) begin
      la2_r   <= la_c;
      ip2_r   <= LOG_ENT_BITS'(lip_c >> FR_LO_BITS);
      lexp2_r <= lexp1_r;
      sd2_r   <= sd1_r;
    end
    if (stage_en[S_LG]) begin
      lg3_r <= lg_c;
      sd3_r <= sd2_r;
    end
    if (stage_en[S_MUL]) begin
      lp4_r <= lp_c;
      sd4_r <= sd3_r;
    end
    if (stage_en[S_EXP]) begin
      ea5_r <= ea_c;
      ep5_r <= EXP_ENT_BITS'(eip_c >> F_LO_BITS);
      n5_r  <= q_c[Q_BITS-1 -: N_BITS];
      sd5_r <= sd4_r;
    end
    if (stage_en[S_POW]) begin
      pm6_r  <= pm_c;
      neg6_r <= sd5_r.neg;
    end
    if (stage_en[S_NUM]) begin
      rf7_r  <= rf_c;
      num7_r <= num_c;
    end
    if (stage_en[S_DIV]) begin
      dd8_r  <= dd_c;
      fin8_r <= fin_c;
    end
    for (int k = 1; k < S_OUT; k++) begin
      if (stage_en[k]) x_r[k] <= x_r[k-1];
    end
  end

  // restoring divider, DIV_STEP quotient bits per stage
  for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
    logic [31:0]         rem_c;
    logic [QUO_BITS-1:0] qb_c;
    logic [31:0]         cand_c;

    always_comb begin
      rem_c  = (d == 0) ? dd8_r : rem_r[(d == 0) ? 0 : d-1];
      qb_c   = (d == 0) ? '0 : q_r[(d == 0) ? 0 : d-1];
      cand_c = '0;
      for (int b = 0; b < DIV_STEP; b++) begin
        cand_c = 32'(dv_c) << (QUO_BITS - 1 - DIV_STEP * d - b);
        if (rem_c >= cand_c) begin
          rem_c = rem_c - cand_c;
          qb_c[QUO_BITS - 1 - DIV_STEP * d - b] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (stage_en[S_QUO + d]) begin
        rem_r[d] <= rem_c;
        q_r[d]   <= qb_c;
        fin_r[d] <= (d == 0) ? fin8_r : fin_r[(d == 0) ? 0 : d-1];
      end
    end
  end

  // sign, saturation, clamps, pass-through
  always_comb begin
    if (ctl.slope == '0) begin
      if (fin_r[DIV_STAGES-1].nzero) rv_c = '0;
      else rv_c = fin_r[DIV_STAGES-1].nneg ? SMIN : SMAX;
    end else if (fin_r[DIV_STAGES-1].qsat) begin
      rv_c = fin_r[DIV_STAGES-1].qneg ? SMIN : SMAX;
    end else begin
      rv_c = fin_r[DIV_STAGES-1].qneg ? -SAMPLE_BITS'(q_r[DIV_STAGES-1])
                                       : SAMPLE_BITS'(q_r[DIV_STAGES-1]);
    end
    r_c = ctl.reverse ? rv_c : $signed(fin_r[DIV_STAGES-1].rf);
    if (ctl.clamp_black && r_c < 0) r_c = '0;
    if (ctl.clamp_white && r_c > SONE) r_c = SONE;
    y_c = ctl.enabled ? r_c : x_r[S_OUT-1];
  end

  always_ff @(posedge clk) begin
    if (stage_en[S_OUT]) y_out <= y_c;
  end

endmodule

/* sv/color_grade_pixel_unit.sv */
// Top level: configuration registers, pipeline valid/stall control, four grading lanes.
//
//   port      dir   handshake          carries
//   in_pix    in    valid/ready        red_in, green_in, blue_in, alpha_in (S3.12)
//   out_pix   out   valid/ready        red_out, green_out, blue_out, alpha_out (S3.12)
//   cfg_*     in    cfg_we, no wait    cfg_addr register index, cfg_data value
//
// One pixel enters per clock while no stall holds the pipeline; its depth NSTG is set
// by the power path (log table, exponent multiply, exp table) and the five-stage divider.
// Each stage holds its item while the next one is full and stalled, so bubbles
// close up and input is taken while a result waits at out_pix.
// Synchronous reset empties the pipeline and restores the register defaults.
module color_grade_pixel_unit import cgp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  cgp_in_if.sink                   in_pix,
  cgp_out_if.source                out_pix,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [CFG_DATA_BITS-1:0] slope_r, intercept_r, exponent_r;
  logic [CHANNEL_COUNT-1:0] enable_r;
  logic                     reverse_r, clamp_blk_r, clamp_wht_r;
  logic [NSTG-1:0]          vld_r;
  logic [NSTG-1:0]          vld_nxt;
  logic [NSTG-1:0]          stage_en;

  logic signed [SAMPLE_BITS-1:0] x_in [CHANNEL_COUNT];
  logic signed [SAMPLE_BITS-1:0] y_out [CHANNEL_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r     <= SLOPE_RST;
      intercept_r <= '0;
      exponent_r  <= EXPONENT_RST;
      enable_r    <= ENABLE_RST;
      reverse_r   <= 1'b0;
      clamp_blk_r <= 1'b1;
      clamp_wht_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SLOPE:     slope_r     <= cfg_data;
        REG_INTERCEPT: intercept_r <= cfg_data;
        REG_EXPONENT:  exponent_r  <= cfg_data;
        REG_ENABLE:    enable_r    <= cfg_data[CHANNEL_COUNT-1:0];
        REG_REVERSE:   reverse_r   <= cfg_data[0];
        REG_CLAMP_BLK: clamp_blk_r <= cfg_data[0];
        REG_CLAMP_WHT: clamp_wht_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // a stage advances when it is empty or its successor advances
  always_comb begin
    stage_en[NSTG-1] = !vld_r[NSTG-1] || out_pix.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
    vld_nxt[0] = stage_en[0] ? in_pix.valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = stage_en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end

  assign in_pix.ready  = stage_en[0];
  assign out_pix.valid = vld_r[NSTG-1];

  assign x_in[0] = in_pix.red_in;
  assign x_in[1] = in_pix.green_in;
  assign x_in[2] = in_pix.blue_in;
  assign x_in[3] = in_pix.alpha_in;

  for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_lane
    lane_ctl_t ctl;

    always_comb begin
      ctl.slope       = slope_r[COEF_BITS*c +: COEF_BITS];
      ctl.intercept   = intercept_r[COEF_BITS*c +: COEF_BITS];
      ctl.exponent    = exponent_r[COEF_BITS*c +: COEF_BITS];
      ctl.enabled     = enable_r[c];
      ctl.reverse     = reverse_r;
      ctl.clamp_black = clamp_blk_r;
      ctl.clamp_white = clamp_wht_r;
    end

    cgp_lane u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .stage_en (stage_en),
      .x_in     (x_in[c]),
      .y_out    (y_out[c])
    );
  end

  assign out_pix.red_out   = y_out[0];
  assign out_pix.green_out = y_out[1];
  assign out_pix.blue_out  = y_out[2];
  assign out_pix.alpha_out = y_out[3];

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_pix.valid)
    else $error("pipeline not empty after reset");

  a_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> (&vld_r))
    else $error("input blocked while a stage is empty");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready) |=> vld_r[0])
    else $error("accepted item missing from first stage");

endmodule
